/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the asynchronous reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked implication: a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/ctsc_pkg.sv */
// Package of types, codes and helper functions for the clock time-setting controller.
package ctsc_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_MINUTE,
		MODE_HOUR,
		MODE_DATE
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_MODE,
		KIND_UP,
		KIND_DOWN
	} kind_t;

	localparam logic [1:0] FIELD_MINUTE = 2'd0;
	localparam logic [1:0] FIELD_HOUR   = 2'd1;
	localparam logic [1:0] FIELD_DATE   = 2'd2;

	localparam int unsigned BTN_MODE = 0;
	localparam int unsigned BTN_UP   = 1;
	localparam int unsigned BTN_DOWN = 2;
	localparam int unsigned NUM_BTN  = 3;

	localparam logic [15:0] AGE_MAX        = 16'hFFFF;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
	localparam logic [5:0]  MINUTE_LAST    = 6'd59;
	localparam logic [6:0]  MINUTE_WRAP    = 7'd60;
	localparam logic [4:0]  HOUR_LAST      = 5'd23;
	localparam logic [5:0]  HOUR_WRAP      = 6'd24;

	// Word index of the debounce register, taken from paddr bit 2.
	localparam logic REG_DEBOUNCE = 1'b0;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] rtc_date;
		logic [3:0] rtc_month;
		logic [6:0] rtc_year;
	} item_t;

	typedef struct packed {
		mode_t      edit_mode;
		logic [5:0] minute_shown;
		logic [4:0] hour_shown;
		logic [4:0] date_shown;
		logic       commit_valid;
		logic [1:0] commit_field;
		logic [5:0] commit_value;
	} result_t;

	// Days in the month; invalid months count as 31 days.
	function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
		logic [4:0] len;
		case (month)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/core/ctsc_if.sv */
// Valid-ready channel interfaces for the input and result beats of the controller.
interface ctsc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [4:0] rtc_date;
	logic [3:0] rtc_month;
	logic [6:0] rtc_year;

	modport source (output valid, output kind, output rtc_date, output rtc_month,
		output rtc_year, input ready);
	modport sink (input valid, input kind, input rtc_date, input rtc_month,
		input rtc_year, output ready);
endinterface

interface ctsc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] edit_mode;
	logic [5:0] minute_shown;
	logic [4:0] hour_shown;
	logic [4:0] date_shown;
	logic       commit_valid;
	logic [1:0] commit_field;
	logic [5:0] commit_value;

	modport source (output valid, output edit_mode, output minute_shown, output hour_shown,
		output date_shown, output commit_valid, output commit_field, output commit_value,
		input ready);
	modport sink (input valid, input edit_mode, input minute_shown, input hour_shown,
		input date_shown, input commit_valid, input commit_field, input commit_value,
		output ready);
endinterface

/* rtl/core/clock_time_set_controller_core.sv */
// Top level of the clock time-setting controller core.
// Each input beat (a millisecond tick or a button edge) yields exactly one result beat
// carrying the edit mode, the edited values and an optional commit to the clock.
// A beat passes an input register and then a result register before its result is offered;
// one beat is accepted every cycle while results are taken.
// Debounce ageing, mode stepping and value stepping are all done in the single stage
// between those registers. The debounce register sits at byte address 0.
module clock_time_set_controller_core
	import ctsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ctsc_in_if.sink     in_ch,
	ctsc_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] debounce_q;
	mode_t       mode_q;
	logic [5:0]  minute_q;
	logic [4:0]  hour_q;
	logic [4:0]  date_q;
	logic        pend_q [NUM_BTN];
	logic [15:0] age_q  [NUM_BTN];

	item_t       item_s1;
	logic        valid_s1;
	result_t     result_q;
	logic        out_valid_q;

	logic        advance;
	logic        cfg_wr;

	mode_t       mode_nxt;
	logic [5:0]  minute_nxt;
	logic [4:0]  hour_nxt;
	logic [4:0]  date_nxt;
	logic        pend_nxt [NUM_BTN];
	logic [15:0] age_nxt  [NUM_BTN];
	logic        fire     [NUM_BTN];
	logic [15:0] age_inc  [NUM_BTN];
	logic [4:0]  len;
	result_t     result_nxt;

	function automatic logic [5:0] minute_step(logic [5:0] v, logic up);
		logic [6:0] inc;
		inc = {1'b0, v} + 7'd1;
		if (up) begin
			return (inc >= MINUTE_WRAP) ? 6'd0 : inc[5:0];
		end
		return (v == 6'd0) ? MINUTE_LAST : v - 6'd1;
	endfunction

	function automatic logic [4:0] hour_step(logic [4:0] v, logic up);
		logic [5:0] inc;
		inc = {1'b0, v} + 6'd1;
		if (up) begin
			return (inc >= HOUR_WRAP) ? 5'd0 : inc[4:0];
		end
		return (v == 5'd0) ? HOUR_LAST : v - 5'd1;
	endfunction

	function automatic logic [4:0] date_step(logic [4:0] v, logic up, logic [4:0] mlen);
		if (up) begin
			return (v >= mlen) ? 5'd1 : v + 5'd1;
		end
		return (v <= 5'd1) ? mlen : v - 5'd1;
	endfunction

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEBOUNCE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEBOUNCE) ? {16'd0, debounce_q} : 32'd0;

	assign len = month_len(item_s1.rtc_month, item_s1.rtc_year);

	always_comb begin
		mode_nxt   = mode_q;
		minute_nxt = minute_q;
		hour_nxt   = hour_q;
		date_nxt   = date_q;
		result_nxt = '0;
		for (int b = 0; b < NUM_BTN; b++) begin
			pend_nxt[b] = pend_q[b];
			age_nxt[b]  = age_q[b];
			fire[b]     = 1'b0;
			age_inc[b]  = (age_q[b] == AGE_MAX) ? age_q[b] : age_q[b] + 16'd1;
		end

		case (item_s1.kind)
			KIND_MODE: begin
				if (!pend_q[BTN_MODE]) begin
					pend_nxt[BTN_MODE] = 1'b1;
					age_nxt[BTN_MODE]  = 16'd0;
				end
			end
			KIND_UP: begin
				pend_nxt[BTN_UP] = 1'b1;
				age_nxt[BTN_UP]  = 16'd0;
			end
			KIND_DOWN: begin
				pend_nxt[BTN_DOWN] = 1'b1;
				age_nxt[BTN_DOWN]  = 16'd0;
			end
			default: begin
				for (int b = 0; b < NUM_BTN; b++) begin
					if (pend_q[b]) begin
						age_nxt[b] = age_inc[b];
						if (age_inc[b] >= debounce_q) begin
							fire[b]     = 1'b1;
							pend_nxt[b] = 1'b0;
						end
					end
				end
			end
		endcase

		if (fire[BTN_MODE]) begin
			case (mode_q)
				MODE_NORMAL: mode_nxt = MODE_MINUTE;
				MODE_MINUTE: begin
					result_nxt.commit_valid = 1'b1;
					result_nxt.commit_field = FIELD_MINUTE;
					result_nxt.commit_value = minute_q;
					mode_nxt = MODE_HOUR;
				end
				MODE_HOUR: begin
					result_nxt.commit_valid = 1'b1;
					result_nxt.commit_field = FIELD_HOUR;
					result_nxt.commit_value = {1'b0, hour_q};
					mode_nxt = MODE_DATE;
				end
				default: begin
					if (item_s1.rtc_date != date_q) begin
						result_nxt.commit_valid = 1'b1;
						result_nxt.commit_field = FIELD_DATE;
						result_nxt.commit_value = {1'b0, date_q};
					end
					mode_nxt = MODE_NORMAL;
				end
			endcase
		end

		if (fire[BTN_UP]) begin
			case (mode_nxt)
				MODE_MINUTE: minute_nxt = minute_step(minute_nxt, 1'b1);
				MODE_HOUR:   hour_nxt   = hour_step(hour_nxt, 1'b1);
				MODE_DATE:   date_nxt   = date_step(date_nxt, 1'b1, len);
				default: ;
			endcase
		end

		if (fire[BTN_DOWN]) begin
			case (mode_nxt)
				MODE_MINUTE: minute_nxt = minute_step(minute_nxt, 1'b0);
				MODE_HOUR:   hour_nxt   = hour_step(hour_nxt, 1'b0);
				MODE_DATE:   date_nxt   = date_step(date_nxt, 1'b0, len);
				default: ;
			endcase
		end

		result_nxt.edit_mode    = mode_nxt;
		result_nxt.minute_shown = minute_nxt;
		result_nxt.hour_shown   = hour_nxt;
		result_nxt.date_shown   = date_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr) begin
			debounce_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.kind      <= kind_t'(in_ch.kind);
			item_s1.rtc_date  <= in_ch.rtc_date;
			item_s1.rtc_month <= in_ch.rtc_month;
			item_s1.rtc_year  <= in_ch.rtc_year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			minute_q <= 6'd0;
			hour_q   <= 5'd0;
			date_q   <= 5'd0;
			for (int b = 0; b < NUM_BTN; b++) begin
				pend_q[b] <= 1'b0;
				age_q[b]  <= 16'd0;
			end
		end else if (advance) begin
			mode_q   <= mode_nxt;
			minute_q <= minute_nxt;
			hour_q   <= hour_nxt;
			date_q   <= date_nxt;
			for (int b = 0; b < NUM_BTN; b++) begin
				pend_q[b] <= pend_nxt[b];
				age_q[b]  <= age_nxt[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.edit_mode    = result_q.edit_mode;
	assign out_ch.minute_shown = result_q.minute_shown;
	assign out_ch.hour_shown   = result_q.hour_shown;
	assign out_ch.date_shown   = result_q.date_shown;
	assign out_ch.commit_valid = result_q.commit_valid;
	assign out_ch.commit_field = result_q.commit_field;
	assign out_ch.commit_value = result_q.commit_value;

endmodule

/* rtl/core/ctsc_checker.sv */
// Port-level checker for the controller core, with the bind that attaches it.
`include "assert_macros.svh"

module ctsc_checker
	import ctsc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] edit_mode,
	input logic       commit_valid,
	input logic [1:0] commit_field,
	input logic [5:0] commit_value
);

	`ASSERT_CLK(a_no_commit_zero, clk, arst_n, (out_valid && !commit_valid) |-> (commit_field == FIELD_MINUTE && commit_value == 6'd0))
	`ASSERT_CLK(a_minute_commit, clk, arst_n, (out_valid && commit_valid && commit_field == FIELD_MINUTE) |-> (edit_mode == MODE_HOUR))
	`ASSERT_CLK(a_hour_commit, clk, arst_n, (out_valid && commit_valid && commit_field == FIELD_HOUR) |-> (edit_mode == MODE_DATE))
	`ASSERT_CLK(a_date_commit, clk, arst_n, (out_valid && commit_valid && commit_field == FIELD_DATE) |-> (edit_mode == MODE_NORMAL))
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(edit_mode) && $stable(commit_value))

endmodule

bind clock_time_set_controller_core ctsc_checker u_ctsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.edit_mode    (out_ch.edit_mode),
	.commit_valid (out_ch.commit_valid),
	.commit_field (out_ch.commit_field),
	.commit_value (out_ch.commit_value)
);

/* tb/clock_time_set_controller_core_test.sv */
// Self-checking testbench for the clock time-setting controller core.
`timescale 1ns / 1ps

module clock_time_set_controller_core_test;
	import ctsc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_BURST = 300;
	localparam logic [2:0] DEBOUNCE_ADDR = {REG_DEBOUNCE, 2'b00};

	localparam result_t RES_CLEAR = '0;
	localparam result_t RES_MINUTE = result_t'({MODE_MINUTE, 25'd0});

	typedef struct {
		bit          cfg;
		logic [15:0] cfg_val;
		kind_t       k;
		logic [4:0]  dt;
		logic [3:0]  mo;
		logic [6:0]  yr;
		bit          typed;
		result_t     want;
	} plan_row_t;

	localparam int PLAN_LEN = 30;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ctsc_in_if  in_ch();
	ctsc_out_if out_ch();

	clock_time_set_controller_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mode_t       cur_mode;
	logic [5:0]  min_val;
	logic [4:0]  hr_val;
	logic [4:0]  day_val;
	bit          btn_wait [NUM_BTN];
	logic [15:0] btn_age [NUM_BTN];
	logic [15:0] debounce;

	result_t pending_display [$];
	int      errors;
	int      beats;
	int      cycles;
	bit      gaps_on;
	bit      hold_results;

	plan_row_t plan [PLAN_LEN] = '{
		'{1'b0, 16'd0, KIND_TICK, 5'd1,  4'd1,  7'd0,   1'b1, RES_CLEAR},
		'{1'b0, 16'd0, KIND_MODE, 5'd31, 4'd12, 7'd99,  1'b1, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd31, 4'd12, 7'd99,  1'b1, RES_CLEAR},
		'{1'b1, 16'd0, KIND_TICK, 5'd0,  4'd0,  7'd0,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd1,  4'd4,  7'd0,   1'b1, RES_MINUTE},
		'{1'b0, 16'd0, KIND_DOWN, 5'd0,  4'd0,  7'd0,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd16, 4'd8,  7'd64,  1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_UP,   5'd2,  4'd1,  7'd1,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd31, 4'd15, 7'd127, 1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_UP,   5'd3,  4'd3,  7'd3,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_MODE, 5'd3,  4'd3,  7'd3,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_DOWN, 5'd3,  4'd3,  7'd3,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_DOWN, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_MODE, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_MODE, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd10, 4'd3,  7'd2,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_DOWN, 5'd5,  4'd2,  7'd4,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd5,  4'd2,  7'd4,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_UP,   5'd5,  4'd2,  7'd5,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd5,  4'd2,  7'd5,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_DOWN, 5'd1,  4'd4,  7'd3,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd1,  4'd4,  7'd3,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_UP,   5'd5,  4'd15, 7'd127, 1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd5,  4'd15, 7'd127, 1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_MODE, 5'd31, 4'd1,  7'd0,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd31, 4'd1,  7'd0,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_UP,   5'd0,  4'd0,  7'd0,   1'b0, RES_CLEAR},
		'{1'b0, 16'd0, KIND_TICK, 5'd0,  4'd0,  7'd0,   1'b0, RES_CLEAR}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int days_in_month(logic [3:0] mo, logic [6:0] yr);
		if (mo == 4'd4 || mo == 4'd6 || mo == 4'd9 || mo == 4'd11)
			return 30;
		if (mo == 4'd2)
			return (yr[1:0] == 2'b00) ? 29 : 28;
		return 31;
	endfunction

	function automatic bit btn_fires(int unsigned b);
		if (!btn_wait[b])
			return 1'b0;
		if (btn_age[b] != AGE_MAX)
			btn_age[b]++;
		if (btn_age[b] >= debounce) begin
			btn_wait[b] = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void step_edit(bit up, logic [3:0] mo, logic [6:0] yr);
		int len;
		len = days_in_month(mo, yr);
		case (cur_mode)
			MODE_MINUTE: begin
				if (up)
					min_val = (int'(min_val) + 1 >= 60) ? 6'd0 : min_val + 6'd1;
				else
					min_val = (min_val == 6'd0) ? 6'd59 : min_val - 6'd1;
			end
			MODE_HOUR: begin
				if (up)
					hr_val = (int'(hr_val) + 1 >= 24) ? 5'd0 : hr_val + 5'd1;
				else
					hr_val = (hr_val == 5'd0) ? 5'd23 : hr_val - 5'd1;
			end
			MODE_DATE: begin
				if (up)
					day_val = (int'(day_val) + 1 >= len + 1) ? 5'd1 : day_val + 5'd1;
				else
					day_val = (day_val <= 5'd1) ? 5'(len) : day_val - 5'd1;
			end
			default: begin
			end
		endcase
	endfunction

	// Mode acts before up and down, which then see the mode already advanced.
	function automatic result_t predict_display(item_t it);
		result_t r;
		r = '0;
		case (it.kind)
			KIND_MODE: begin
				if (!btn_wait[BTN_MODE]) begin
					btn_wait[BTN_MODE] = 1'b1;
					btn_age[BTN_MODE] = '0;
				end
			end
			KIND_UP: begin
				btn_wait[BTN_UP] = 1'b1;
				btn_age[BTN_UP] = '0;
			end
			KIND_DOWN: begin
				btn_wait[BTN_DOWN] = 1'b1;
				btn_age[BTN_DOWN] = '0;
			end
			default: begin
				if (btn_fires(BTN_MODE)) begin
					case (cur_mode)
						MODE_NORMAL: cur_mode = MODE_MINUTE;
						MODE_MINUTE: begin
							r.commit_valid = 1'b1;
							r.commit_field = FIELD_MINUTE;
							r.commit_value = min_val;
							cur_mode = MODE_HOUR;
						end
						MODE_HOUR: begin
							r.commit_valid = 1'b1;
							r.commit_field = FIELD_HOUR;
							r.commit_value = {1'b0, hr_val};
							cur_mode = MODE_DATE;
						end
						default: begin
							if (it.rtc_date != day_val) begin
								r.commit_valid = 1'b1;
								r.commit_field = FIELD_DATE;
								r.commit_value = {1'b0, day_val};
							end
							cur_mode = MODE_NORMAL;
						end
					endcase
				end
				if (btn_fires(BTN_UP))
					step_edit(1'b1, it.rtc_month, it.rtc_year);
				if (btn_fires(BTN_DOWN))
					step_edit(1'b0, it.rtc_month, it.rtc_year);
			end
		endcase
		r.edit_mode = cur_mode;
		r.minute_shown = min_val;
		r.hour_shown = hr_val;
		r.date_shown = day_val;
		return r;
	endfunction

	// Now and then a tick carries the edited day as the clock's day, so that an unchanged
	// date is left without a commit.
	function automatic item_t random_item(kind_t k);
		item_t it;
		it.kind = k;
		it.rtc_date = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(1, 31));
		it.rtc_month = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(1, 12));
		it.rtc_year = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, 99));
		if (k == KIND_TICK && cur_mode == MODE_DATE && $urandom_range(0, 3) == 0)
			it.rtc_date = day_val;
		return it;
	endfunction

	task automatic report_fault(string msg);
		errors++;
		if (errors <= 200)
			$display("%s", msg);
	endtask

	task automatic check_field(string name, logic [5:0] got, logic [5:0] want);
		if (got !== want)
			report_fault($sformatf("beat %0d: %s is %0d, expected %0d", beats, name, got, want));
	endtask

	task automatic send_item(item_t it, bit typed, result_t want);
		int gap;
		result_t predicted;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= it.kind;
		in_ch.rtc_date <= it.rtc_date;
		in_ch.rtc_month <= it.rtc_month;
		in_ch.rtc_year <= it.rtc_year;
		do @(posedge clk); while (!in_ch.ready);
		predicted = predict_display(it);
		pending_display.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_display.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_debounce(logic [15:0] val);
		wait_drained();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEBOUNCE_ADDR;
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		debounce = val;
	endtask

	// Mostly an edge followed by enough ticks for it to act (at most MAX_BURST), with random noise,
	// bursts cut short of the debounce time and, with squeeze, results held back once.
	task automatic run_phase(logic [15:0] dbn, int n_items, bit gaps, bit squeeze);
		int sent;
		int ticks;
		int pick;
		bit paused;
		kind_t k;
		write_debounce(dbn);
		gaps_on = gaps;
		sent = 0;
		paused = 1'b0;
		if (squeeze)
			hold_results = 1'b1;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 3) begin
				send_item(random_item(kind_t'($urandom_range(0, 3))), 1'b0, RES_CLEAR);
				sent++;
			end else begin
				pick = $urandom_range(0, 3);
				k = (pick < 2) ? KIND_MODE : (pick == 2) ? KIND_UP : KIND_DOWN;
				send_item(random_item(k), 1'b0, RES_CLEAR);
				sent++;
				ticks = ($urandom_range(0, 9) < 7) ? int'(dbn) + $urandom_range(0, 1)
					: $urandom_range(0, int'(dbn));
				if (ticks > MAX_BURST)
					ticks = MAX_BURST;
				if (ticks > n_items - sent)
					ticks = n_items - sent;
				repeat (ticks) begin
					send_item(random_item(KIND_TICK), 1'b0, RES_CLEAR);
					sent++;
				end
			end
			if (squeeze && !paused && sent >= n_items / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_TICK;
		in_ch.rtc_date <= '0;
		in_ch.rtc_month <= '0;
		in_ch.rtc_year <= '0;
		out_ch.ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		errors = 0;
		beats = 0;
		gaps_on = 1'b1;
		hold_results = 1'b0;
		cur_mode = MODE_NORMAL;
		min_val = '0;
		hr_val = '0;
		day_val = '0;
		debounce = DEBOUNCE_RESET;
		for (int b = 0; b < NUM_BTN; b++) begin
			btn_wait[b] = 1'b0;
			btn_age[b] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].cfg)
				write_debounce(plan[i].cfg_val);
			else
				send_item(item_t'({plan[i].k, plan[i].dt, plan[i].mo, plan[i].yr}),
					plan[i].typed, plan[i].want);
		end
		run_phase(16'd1, 300, 1'b1, 1'b0);
		run_phase(16'd0, 300, 1'b0, 1'b0);
		run_phase(16'd3, 300, 1'b1, 1'b1);
		run_phase(16'd2, 250, 1'b1, 1'b0);
		run_phase(DEBOUNCE_RESET, 320, 1'b1, 1'b0);
		run_phase(16'hFFFF, 60, 1'b1, 1'b0);
		run_phase(16'd5, 150, 1'b1, 1'b0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_display.size() != 0)
			report_fault($sformatf("%0d results never arrived", pending_display.size()));
		if (errors == 0)
			$display("clock_time_set_controller_core_test: clean");
		else
			$display("clock_time_set_controller_core_test: errors");
		$finish;
	end

	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_display.size() == 0) begin
				report_fault($sformatf("beat %0d: result with nothing outstanding", beats));
			end else begin
				want = pending_display.pop_front();
				check_field("edit_mode", 6'(out_ch.edit_mode), 6'(want.edit_mode));
				check_field("minute_shown", out_ch.minute_shown, want.minute_shown);
				check_field("hour_shown", 6'(out_ch.hour_shown), 6'(want.hour_shown));
				check_field("date_shown", 6'(out_ch.date_shown), 6'(want.date_shown));
				check_field("commit_valid", 6'(out_ch.commit_valid), 6'(want.commit_valid));
				check_field("commit_field", 6'(out_ch.commit_field), 6'(want.commit_field));
				check_field("commit_value", out_ch.commit_value, want.commit_value);
			end
			beats++;
		end
	end

	initial begin : watchdog
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("clock_time_set_controller_core_test: errors");
				$finish;
			end
		end
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ctsc_pkg.sv
rtl/core/ctsc_if.sv
rtl/core/clock_time_set_controller_core.sv
rtl/core/ctsc_checker.sv
tb/clock_time_set_controller_core_test.sv
